// ===== src/dss_pkg.sv =====
// Package for the delimiter stream splitter: widths, defaults, register
// indexes and the transaction payload types. No dependencies.
`default_nettype none
package dss_pkg;

   localparam int DELIM_MAX_DEF = 8;
   localparam int POS_BITS_DEF  = 16;

   localparam int LEN_W    = 4;
   localparam int BYTES_W  = 64;
   localparam int MAXSEG_W = 16;
   localparam int FIELD_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 64;

   localparam int RSP_DEPTH = 4;

   localparam logic [LEN_W-1:0]    DELIM_LEN_RST    = 4'd2;
   localparam logic [BYTES_W-1:0]  DELIM_BYTES_RST  = 64'h0A0D;
   localparam logic [MAXSEG_W-1:0] MAX_SEGMENTS_RST = 16'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELIM_LEN    = 2'd0,
      CSR_DELIM_BYTES  = 2'd1,
      CSR_MAX_SEGMENTS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [FIELD_W-1:0] seg_start;
      logic [FIELD_W-1:0] seg_length;
      logic               is_final;
      logic               truncated;
   } rsp_payload_type;

   typedef struct packed {
      logic [LEN_W-1:0]    delim_len;
      logic [BYTES_W-1:0]  delim_bytes;
      logic [MAXSEG_W-1:0] max_segments;
   } cfg_type;

   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type first;
      rsp_payload_type second;
   } push_type;

endpackage
`default_nettype wire

// ===== src/dss_chan_if.sv =====
// Valid/ready channel carrying one payload per transaction.
// Payload type is handed in as a type parameter.
`default_nettype none
interface dss_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/dss_core.sv =====
// Splitter datapath: delimiter window compare, string state and result
// assembly for one byte per cycle while step is high. Uses dss_pkg.
`default_nettype none
module dss_core #(
   parameter int DELIM_MAX = dss_pkg::DELIM_MAX_DEF,
   parameter int POS_BITS  = dss_pkg::POS_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire dss_pkg::req_payload_type item,
   input  wire dss_pkg::cfg_type         cfg,
   output dss_pkg::push_type             push
);
   import dss_pkg::*;

   localparam int WIN_W = 8 * DELIM_MAX;
   localparam int BSM_W = $clog2(DELIM_MAX + 1);

   logic [WIN_W-1:0]    win_ff,  win_in;
   logic [POS_BITS-1:0] pos_ff,  pos_in;
   logic [POS_BITS-1:0] beg_ff,  beg_in;
   logic [BSM_W-1:0]    bsm_ff,  bsm_in;
   logic [MAXSEG_W-1:0] cnt_ff,  cnt_in;
   logic                stop_ff, stop_in;

   logic [LEN_W-1:0]    len_act;
   logic [WIN_W-1:0]    win_shift;
   logic                hit;
   logic [POS_BITS-1:0] seg_len;

   function automatic push_type push_add(push_type p, rsp_payload_type r);
      push_type q;
      q = p;
      if (p.count == 2'd0) begin
         q.first = r;
      end else begin
         q.second = r;
      end
      q.count = p.count + 2'd1;
      return q;
   endfunction

   function automatic rsp_payload_type mk_res(logic [POS_BITS-1:0] start,
                                              logic [POS_BITS-1:0] len,
                                              logic fin, logic trunc);
      rsp_payload_type r;
      r.seg_start  = FIELD_W'(start);
      r.seg_length = FIELD_W'(len);
      r.is_final   = fin;
      r.truncated  = trunc;
      return r;
   endfunction

   always_comb begin
      if (cfg.delim_len == '0) begin
         len_act = LEN_W'(1);
      end else if (cfg.delim_len > LEN_W'(DELIM_MAX)) begin
         len_act = LEN_W'(DELIM_MAX);
      end else begin
         len_act = cfg.delim_len;
      end
   end

   assign win_shift = (win_ff >> 8) | (WIN_W'(item.data_byte) << (WIN_W - 8));

   always_comb begin
      logic all_eq;
      hit = 1'b0;
      for (int l = 1; l <= DELIM_MAX; l++) begin
         all_eq = 1'b1;
         for (int i = 0; i < l; i++) begin
            if (cfg.delim_bytes[8*i +: 8] != win_shift[8*(DELIM_MAX-l+i) +: 8]) begin
               all_eq = 1'b0;
            end
         end
         if (len_act == LEN_W'(l)) begin
            hit = all_eq;
         end
      end
   end

   assign seg_len = pos_ff + POS_BITS'(1) - POS_BITS'(len_act) - beg_ff;

   always_comb begin
      logic trunc_hit;
      win_in    = win_ff;
      pos_in    = pos_ff;
      beg_in    = beg_ff;
      bsm_in    = bsm_ff;
      cnt_in    = cnt_ff;
      stop_in   = stop_ff;
      push      = '0;
      trunc_hit = 1'b0;
      if (step) begin
         if (stop_ff) begin
            trunc_hit = 1'b0;
         end else if (pos_ff == '1) begin
            push    = push_add(push, mk_res(beg_ff, '0, 1'b1, 1'b1));
            stop_in = 1'b1;
         end else begin
            win_in = win_shift;
            pos_in = pos_ff + POS_BITS'(1);
            if (bsm_ff < BSM_W'(DELIM_MAX)) begin
               bsm_in = bsm_ff + BSM_W'(1);
            end
            if (hit && (LEN_W'(bsm_in) >= len_act)) begin
               if (cnt_ff < cfg.max_segments) begin
                  if (seg_len != '0) begin
                     push   = push_add(push, mk_res(beg_ff, seg_len, 1'b0, 1'b0));
                     cnt_in = cnt_ff + MAXSEG_W'(1);
                  end
                  beg_in = pos_in;
                  bsm_in = '0;
               end else begin
                  push      = push_add(push, mk_res(beg_ff, '0, 1'b1, 1'b1));
                  stop_in   = 1'b1;
                  trunc_hit = 1'b1;
               end
            end
            if (item.end_of_string && !trunc_hit) begin
               if (cnt_in < cfg.max_segments) begin
                  push = push_add(push, mk_res(beg_in, pos_in - beg_in, 1'b1, 1'b0));
               end else begin
                  push = push_add(push, mk_res(beg_in, '0, 1'b1, 1'b1));
               end
            end
         end
         if (item.end_of_string) begin
            win_in  = '0;
            pos_in  = '0;
            beg_in  = '0;
            bsm_in  = '0;
            cnt_in  = '0;
            stop_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         pos_ff  <= '0;
         beg_ff  <= '0;
         bsm_ff  <= '0;
         cnt_ff  <= '0;
         stop_ff <= 1'b0;
      end else begin
         win_ff  <= win_in;
         pos_ff  <= pos_in;
         beg_ff  <= beg_in;
         bsm_ff  <= bsm_in;
         cnt_ff  <= cnt_in;
         stop_ff <= stop_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/dss_rsp_fifo.sv =====
// Result queue: takes up to two results per cycle, drives the rsp channel.
// Uses dss_pkg and dss_chan_if.
`default_nettype none
module dss_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dss_pkg::push_type push,
   output logic                   room,
   dss_chan_if.source             rsp_chan
);
   import dss_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_payload_type mem [RSP_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             pop;

   assign pop              = rsp_chan.valid && rsp_chan.ready;
   assign room             = count_ff <= CNT_W'(RSP_DEPTH - 2);
   assign rsp_chan.valid   = count_ff != '0;
   assign rsp_chan.payload = mem[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/delimiter_stream_splitter.sv =====
// Top level of the delimiter stream splitter: input register, control
// registers, datapath and result queue. Uses dss_pkg, dss_chan_if,
// dss_core and dss_rsp_fifo.
//
//   channel   dir  transaction
//   req_chan  in   one string byte plus end-of-string flag
//   rsp_chan  out  one segment: start, length, final, truncated
//   csr_*     in   register write: index and data, no read-back
//
// One byte is taken per cycle while the queue has room; it is registered in
// the input register, then split, and its up to two results are written
// into the four-entry queue, from which they leave on rsp_chan.
// Bytes keep flowing while at least two queue entries are free; a stalled
// rsp side fills the queue and then holds req_chan.ready low.
// Reset (synchronous) empties the queue and the input register and loads
// the register defaults: delimiter CR LF, limit 64 segments.
`default_nettype none
module delimiter_stream_splitter #(
   parameter int DELIM_MAX = dss_pkg::DELIM_MAX_DEF,
   parameter int POS_BITS  = dss_pkg::POS_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   dss_chan_if.sink                              req_chan,
   dss_chan_if.source                            rsp_chan,
   input  wire logic                             csr_wr_en,
   input  wire logic [dss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dss_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import dss_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff;
   cfg_type         cfg_ff;
   push_type        push;
   logic            room;
   logic            step;

   assign step           = in_valid_ff && room;
   assign req_chan.ready = !in_valid_ff || room;
   assign in_valid_in    = req_chan.valid || (in_valid_ff && !room);

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff <= req_chan.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim_len    <= DELIM_LEN_RST;
         cfg_ff.delim_bytes  <= DELIM_BYTES_RST;
         cfg_ff.max_segments <= MAX_SEGMENTS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DELIM_LEN: begin
               cfg_ff.delim_len <= csr_wr_data[LEN_W-1:0];
            end
            CSR_DELIM_BYTES: begin
               cfg_ff.delim_bytes <= csr_wr_data[BYTES_W-1:0];
            end
            CSR_MAX_SEGMENTS: begin
               cfg_ff.max_segments <= csr_wr_data[MAXSEG_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   dss_core #(
      .DELIM_MAX (DELIM_MAX),
      .POS_BITS  (POS_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_item_ff),
      .cfg   (cfg_ff),
      .push  (push)
   );

   dss_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
